/* rtl/mras_pkg.sv */
package mras_pkg;

  localparam int unsigned MAX_COLUMNS = 1024;
  localparam int unsigned MAX_ROWS    = 1024;

  localparam int unsigned COL_W   = $clog2(MAX_COLUMNS);
  localparam int unsigned CNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned H_W     = ROW_W;
  localparam int unsigned ENTRY_W = H_W + COL_W;
  localparam int unsigned CELL_W  = 1 + H_W;
  localparam int unsigned SUM_W   = 63;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned MUL_W   = 32;

  localparam logic [2:0] REG_COLORS_COUNTED = 3'd0;

  typedef struct packed {
    logic [H_W-1:0]   h;
    logic [COL_W-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic             color;
    logic [H_W-1:0]   h;
  } cell_t;

  typedef struct packed {
    logic [H_W-1:0]   h;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } pop_t;

endpackage

/* rtl/mras_in_if.sv */
interface mras_in_if;
  logic valid;
  logic ready;
  logic pixel;
  logic row_end;
  logic image_end;

  modport source (output valid, output pixel, output row_end, output image_end, input ready);
  modport sink   (input valid, input pixel, input row_end, input image_end, output ready);
endinterface

/* rtl/mras_out_if.sv */
interface mras_out_if;
  logic                            valid;
  logic                            ready;
  logic [mras_pkg::SUM_W-1:0]      area_sum;
  logic                            size_error;

  modport source (output valid, output area_sum, output size_error, input ready);
  modport sink   (input valid, input area_sum, input size_error, output ready);
endinterface

/* rtl/mras_ram.sv */
module mras_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mras_contrib.sv */
module mras_contrib (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  mras_pkg::pop_t              pop_i,
  output logic                        done_o,
  output logic [mras_pkg::ACC_W-1:0]  value_o
);

  localparam logic [2:0] ST_TA = 3'd0;
  localparam logic [2:0] ST_X  = 3'd1;
  localparam logic [2:0] ST_TB = 3'd2;
  localparam logic [2:0] ST_Y  = 3'd3;
  localparam logic [2:0] ST_Z  = 3'd4;
  localparam logic [2:0] ST_TH = 3'd5;
  localparam logic [2:0] ST_R  = 3'd6;

  localparam int unsigned MW = mras_pkg::MUL_W;

  logic                  busy_q;
  logic [2:0]            step_q;
  mras_pkg::pop_t        op_q;
  logic [MW-1:0]         t_q, x_q, y_q, z_q, w_q;
  logic [2*MW-1:0]       value_q;
  logic                  done_q;
  logic [MW-1:0]         mul_a, mul_b, ext_a, ext_b, ext_h;
  logic [2*MW-1:0]       prod;

  assign ext_a = MW'(op_q.a);
  assign ext_b = MW'(op_q.b);
  assign ext_h = MW'(op_q.h);

  always_comb begin
    case (step_q)
      ST_TA:   begin mul_a = ext_a; mul_b = ext_a + MW'(1); end
      ST_X:    begin mul_a = t_q;   mul_b = ext_b;          end
      ST_TB:   begin mul_a = ext_b; mul_b = ext_b + MW'(1); end
      ST_Y:    begin mul_a = t_q;   mul_b = ext_a;          end
      ST_Z:    begin mul_a = ext_a; mul_b = ext_b;          end
      ST_TH:   begin mul_a = ext_h; mul_b = ext_h + MW'(1); end
      ST_R:    begin mul_a = t_q;   mul_b = w_q;            end
      default: begin mul_a = '0;    mul_b = '0;             end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_TA;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= ST_TA;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == ST_R) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= pop_i;
    end else if (busy_q) begin
      case (step_q)
        ST_TA:   t_q <= prod[MW:1];
        ST_X:    x_q <= prod[MW-1:0];
        ST_TB:   t_q <= prod[MW:1];
        ST_Y:    y_q <= prod[MW-1:0];
        ST_Z:    z_q <= prod[MW-1:0];
        ST_TH:   begin
          t_q <= prod[MW:1];
          w_q <= x_q + y_q - z_q;
        end
        ST_R:    value_q <= prod;
        default: ;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q[mras_pkg::ACC_W-1:0];

endmodule

/* rtl/monochrome_rectangle_area_sum.sv */
// Channel   Dir  Transfer payload
// in_i      in   pixel, row_end, image_end
// out_o     out  area_sum, size_error (one per image_end)
// APB       in   colors_counted at byte address 0
//
// Each stack pop adds a read-modify chain on the stack RAM and, for a
// counted colour, 7 steps of the shared multiplier. A row end pops every
// column still on either stack.
// After reset and after each result a pass clears the column RAM;
// no pixel is taken then. A pending result blocks only the next image end.
module monochrome_rectangle_area_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  mras_in_if.sink     in_i,
  mras_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned COL_W   = mras_pkg::COL_W;
  localparam int unsigned CNT_W   = mras_pkg::CNT_W;
  localparam int unsigned ROW_W   = mras_pkg::ROW_W;
  localparam int unsigned H_W     = mras_pkg::H_W;
  localparam int unsigned ACC_W   = mras_pkg::ACC_W;
  localparam int unsigned SUM_W   = mras_pkg::SUM_W;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(mras_pkg::MAX_COLUMNS);
  localparam logic [ROW_W-1:0] MAXR = ROW_W'(mras_pkg::MAX_ROWS);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_COLRD  = 4'd2;
  localparam logic [3:0] S_PRD    = 4'd3;
  localparam logic [3:0] S_PWAIT  = 4'd4;
  localparam logic [3:0] S_PCMP   = 4'd5;
  localparam logic [3:0] S_PLEFT  = 4'd6;
  localparam logic [3:0] S_PSTART = 4'd7;
  localparam logic [3:0] S_PMUL   = 4'd8;
  localparam logic [3:0] S_PPOP   = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;
  localparam logic [3:0] S_CNEXT  = 4'd11;
  localparam logic [3:0] S_ADV    = 4'd12;
  localparam logic [3:0] S_FINISH = 4'd13;

  logic [3:0]        state_q;
  logic [1:0]        mask_q;
  logic [COL_W-1:0]  clr_q;
  logic [CNT_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  top_q [2];
  logic              color_q;
  logic              closing_q;
  logic              has_below_q;
  logic              pix_q, row_end_q, img_end_q;
  logic [H_W-1:0]    h_q;
  mras_pkg::entry_t  entry_q, below_q;
  logic [ACC_W-1:0]  acc_q;
  logic              ovf_q;
  logic              out_valid_q;
  logic [SUM_W-1:0]  area_q;
  logic              err_q;

  logic              in_acc, oob;
  mras_pkg::cell_t   cell_rd, cell_wr;
  logic              col_re, col_we;
  logic [COL_W-1:0]  col_waddr;
  logic [H_W:0]      h_inc;
  logic [H_W-1:0]    h_new, hj;
  logic [CNT_W-1:0]  top_c;
  logic              pop_c;
  logic              st_re, st_we;
  logic [COL_W:0]    st_raddr, st_waddr;
  logic [mras_pkg::ENTRY_W-1:0] st_rdata;
  mras_pkg::entry_t  st_rd, push_e;
  mras_pkg::pop_t    pop_op;
  logic              mul_start, mul_done;
  logic [ACC_W-1:0]  mul_val;
  logic [ACC_W:0]    acc_sum;
  logic              out_free;
  logic              cfg_we;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == mras_pkg::REG_COLORS_COUNTED);
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, mask_q} : 32'd0;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign oob        = (col_q >= MAXC) || (row_q >= MAXR);

  // column store: {color, run height}
  assign col_re    = in_acc && !oob;
  assign col_we    = (state_q == S_CLEAR) || (state_q == S_COLRD);
  assign col_waddr = (state_q == S_CLEAR) ? clr_q : col_q[COL_W-1:0];
  assign h_inc     = (cell_rd.color == pix_q) ? ({1'b0, cell_rd.h} + (H_W+1)'(1))
                                              : (H_W+1)'(1);
  assign h_new     = (h_inc > (H_W+1)'(MAXR)) ? MAXR : h_inc[H_W-1:0];
  assign cell_wr   = (state_q == S_CLEAR) ? '0 : mras_pkg::cell_t'{color: pix_q, h: h_new};

  mras_ram #(.WIDTH(mras_pkg::CELL_W), .DEPTH(mras_pkg::MAX_COLUMNS)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (cell_wr),
    .re_i    (col_re),
    .raddr_i (col_q[COL_W-1:0]),
    .rdata_o (cell_rd)
  );

  // stacks for both colours share one RAM, colour is the top address bit
  assign top_c  = top_q[color_q];
  assign hj     = (color_q == pix_q) ? h_q : '0;
  assign pop_c  = closing_q || (entry_q.h > hj);
  assign st_rd  = st_rdata;
  assign push_e = '{h: hj, idx: col_q[COL_W-1:0]};

  always_comb begin
    st_re    = 1'b0;
    st_raddr = {color_q, COL_W'(top_c - CNT_W'(1))};
    if (state_q == S_PRD) begin
      st_re = (top_c != '0);
    end else if (state_q == S_PCMP) begin
      st_re    = pop_c && (top_c > CNT_W'(1));
      st_raddr = {color_q, COL_W'(top_c - CNT_W'(2))};
    end
  end

  assign st_we    = (state_q == S_PUSH) && (top_c < MAXC);
  assign st_waddr = {color_q, top_c[COL_W-1:0]};

  mras_ram #(.WIDTH(mras_pkg::ENTRY_W), .DEPTH(2 * mras_pkg::MAX_COLUMNS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (push_e),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // span widths: left edge after the entry below, right edge at col_q - 1
  assign pop_op.h  = entry_q.h;
  assign pop_op.a  = has_below_q ? (CNT_W'(entry_q.idx) - CNT_W'(below_q.idx))
                                 : (CNT_W'(entry_q.idx) + CNT_W'(1));
  assign pop_op.b  = col_q - CNT_W'(entry_q.idx);
  assign mul_start = (state_q == S_PSTART);

  mras_contrib u_contrib (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .pop_i   (pop_op),
    .done_o  (mul_done),
    .value_o (mul_val)
  );

  assign acc_sum  = {1'b0, acc_q} + {1'b0, mul_val};
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mask_q      <= 2'd3;
      clr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      top_q[0]    <= '0;
      top_q[1]    <= '0;
      color_q     <= 1'b0;
      closing_q   <= 1'b0;
      has_below_q <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_q <= pwdata[1:0];
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + COL_W'(1);
          if (clr_q == COL_W'(mras_pkg::MAX_COLUMNS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            color_q   <= 1'b0;
            closing_q <= 1'b0;
            if (oob) begin
              ovf_q   <= 1'b1;
              state_q <= S_ADV;
            end else begin
              state_q <= S_COLRD;
            end
          end
        end
        S_COLRD: begin
          h_q     <= h_new;
          state_q <= S_PRD;
        end
        S_PRD: begin
          if (top_c != '0) begin
            state_q <= S_PWAIT;
          end else begin
            state_q <= closing_q ? S_CNEXT : S_PUSH;
          end
        end
        S_PWAIT: begin
          entry_q <= st_rd;
          state_q <= S_PCMP;
        end
        S_PCMP: begin
          if (!pop_c) begin
            state_q <= S_PUSH;
          end else if (top_c > CNT_W'(1)) begin
            state_q <= S_PLEFT;
          end else begin
            has_below_q <= 1'b0;
            state_q     <= mask_q[color_q] ? S_PSTART : S_PPOP;
          end
        end
        S_PLEFT: begin
          below_q     <= st_rd;
          has_below_q <= 1'b1;
          state_q     <= mask_q[color_q] ? S_PSTART : S_PPOP;
        end
        S_PSTART: begin
          state_q <= S_PMUL;
        end
        S_PMUL: begin
          if (mul_done) begin
            acc_q   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            state_q <= S_PPOP;
          end
        end
        S_PPOP: begin
          top_q[color_q] <= top_c - CNT_W'(1);
          if (has_below_q) begin
            entry_q <= below_q;
            state_q <= S_PCMP;
          end else begin
            state_q <= closing_q ? S_CNEXT : S_PUSH;
          end
        end
        S_PUSH: begin
          if (top_c < MAXC) begin
            top_q[color_q] <= top_c + CNT_W'(1);
          end
          state_q <= S_CNEXT;
        end
        S_CNEXT: begin
          if (color_q == 1'b0) begin
            color_q <= 1'b1;
            state_q <= S_PRD;
          end else if (!closing_q) begin
            state_q <= S_ADV;
          end else begin
            col_q <= '0;
            if (row_q < MAXR) begin
              row_q <= row_q + ROW_W'(1);
            end
            state_q <= img_end_q ? S_FINISH : S_IDLE;
          end
        end
        S_ADV: begin
          if (col_q < MAXC) begin
            col_q <= col_q + CNT_W'(1);
          end
          if (row_end_q || img_end_q) begin
            closing_q <= 1'b1;
            color_q   <= 1'b0;
            state_q   <= S_PRD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            acc_q       <= '0;
            ovf_q       <= 1'b0;
            row_q       <= '0;
            col_q       <= '0;
            top_q[0]    <= '0;
            top_q[1]    <= '0;
            clr_q       <= '0;
            state_q     <= S_CLEAR;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q     <= in_i.pixel;
      row_end_q <= in_i.row_end;
      img_end_q <= in_i.image_end;
    end
    if (state_q == S_FINISH && out_free) begin
      err_q  <= ovf_q;
      area_q <= ovf_q ? '0 : (acc_q[ACC_W-1] ? '1 : acc_q[SUM_W-1:0]);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.area_sum   = area_q;
  assign out_o.size_error = err_q;

  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_PMUL)
    else $error("multiplier result outside its wait state");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q[0] <= MAXC && top_q[1] <= MAXC)
    else $error("stack top beyond depth");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside image end");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_i.ready)
    else $error("pixel transfer during clearing pass");

endmodule
